[hdl/chc_pkg.sv]
// ----------------------------------------------------------------------------
// chc_pkg: shared types and constants of the chunk header compressor
// Request/response payloads, the per-stream table entry, status and header
// format codes, and the small lookup functions used by the core.
// ----------------------------------------------------------------------------
`default_nettype none

package chc_pkg;

  // Stream table depth; a power of two between 8 and 64.
  localparam int TABLE_SLOTS = 8;
  localparam int SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int PROBE_W     = SLOT_W + 1;

  // Field widths
  localparam int ID_W     = 17;
  localparam int STAMP_W  = 32;
  localparam int LEN_W    = 24;
  localparam int TYPE_W   = 8;
  localparam int STREAM_W = 32;
  localparam int FMT_W    = 2;
  localparam int STATUS_W = 2;
  localparam int CSIZE_W  = 16;
  localparam int COUNT_W  = 18;
  localparam int FIRST_W  = 5;
  localparam int NEXT_W   = 3;

  // Legal chunk stream ids
  localparam logic [ID_W-1:0] ID_MIN = 17'd2;
  localparam logic [ID_W-1:0] ID_MAX = 17'd65599;

  // Basic header size thresholds
  localparam logic [ID_W-1:0] BASIC2_ID = 17'd64;
  localparam logic [ID_W-1:0] BASIC3_ID = 17'd320;

  // Slots that hold their own index after reset
  localparam int PRESET_LO = 2;
  localparam int PRESET_HI = 6;

  localparam logic [STAMP_W-1:0] STAMP_LIMIT = 32'h00FF_FFFF;
  localparam logic [LEN_W-1:0]   LEN_LIMIT   = 24'hFF_FFFF;
  localparam int                 EXT_BYTES   = 4;

  localparam logic [CSIZE_W-1:0] CHUNK_MIN   = 16'd128;
  localparam logic [CSIZE_W-1:0] CHUNK_RESET = 16'd128;

  // Divider: quotient bits retired per cycle
  localparam int DIV_STEP_BITS = 2;
  localparam int DIV_CYCLES    = LEN_W / DIV_STEP_BITS;
  localparam int DIV_CNT_W     = $clog2(DIV_CYCLES + 1);

  // Status codes
  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_CHANNEL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_TOO_LONG   = 2'd2;

  // Chunk header formats
  localparam logic [FMT_W-1:0] FMT_FULL       = 2'd0;
  localparam logic [FMT_W-1:0] FMT_SAME_STRM  = 2'd1;
  localparam logic [FMT_W-1:0] FMT_SAME_SHAPE = 2'd2;
  localparam logic [FMT_W-1:0] FMT_SAME_DELTA = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0]     channel_id;
    logic [STAMP_W-1:0]  msg_timestamp;
    logic [LEN_W-1:0]    msg_length;
    logic [TYPE_W-1:0]   msg_type;
    logic [STREAM_W-1:0] msg_stream;
    logic                allow_compress;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FMT_W-1:0]    header_format;
    logic [STAMP_W-1:0]  stamp_field;
    logic                extended_stamp;
    logic [FIRST_W-1:0]  first_header_bytes;
    logic [NEXT_W-1:0]   next_header_bytes;
    logic [COUNT_W-1:0]  chunk_count;
  } rsp_t;

  // One table entry: last header sent on a chunk stream
  typedef struct packed {
    logic [ID_W-1:0]     channel;
    logic [FMT_W-1:0]    format;
    logic [STAMP_W-1:0]  stamp;
    logic [LEN_W-1:0]    length;
    logic [TYPE_W-1:0]   msg_type;
    logic [STREAM_W-1:0] stream;
    logic [STAMP_W-1:0]  clock;
  } slot_entry_t;

  localparam int ENTRY_W = $bits(slot_entry_t);

  // Contents of a slot that was never written
  function automatic slot_entry_t preset_entry(input logic [SLOT_W-1:0] idx);
    slot_entry_t e;
    e = '0;
    if (int'(idx) >= PRESET_LO && int'(idx) <= PRESET_HI) begin
      e.channel = ID_W'(idx);
    end
    return e;
  endfunction

  // Basic header bytes for a chunk stream id
  function automatic logic [1:0] basic_bytes(input logic [ID_W-1:0] id);
    logic [1:0] b;
    if (id < BASIC2_ID) begin
      b = 2'd1;
    end else if (id < BASIC3_ID) begin
      b = 2'd2;
    end else begin
      b = 2'd3;
    end
    return b;
  endfunction

  // Message header bytes per format
  function automatic logic [3:0] msg_bytes(input logic [FMT_W-1:0] fmt);
    logic [3:0] m;
    unique case (fmt)
      FMT_FULL:       m = 4'd11;
      FMT_SAME_STRM:  m = 4'd7;
      FMT_SAME_SHAPE: m = 4'd3;
      default:        m = 4'd0;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

[hdl/chc_ram.sv]
// ----------------------------------------------------------------------------
// chc_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module chc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[hdl/chc_div.sv]
// ----------------------------------------------------------------------------
// chc_div: chunk count divider
// Restoring division of the message length by the chunk size, two quotient
// bits per cycle; the result is rounded up (ceiling).
// ----------------------------------------------------------------------------
`default_nettype none

module chc_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [chc_pkg::LEN_W-1:0]     dividend,
  input  wire logic [chc_pkg::CSIZE_W-1:0]   divisor,
  output logic                               busy,
  output logic      [chc_pkg::COUNT_W-1:0]   quotient
);

  logic [chc_pkg::LEN_W-1:0]     acc;     // dividend bits shift out, quotient in
  logic [chc_pkg::CSIZE_W-1:0]   rem;
  logic [chc_pkg::CSIZE_W-1:0]   dsr;
  logic [chc_pkg::DIV_CNT_W-1:0] cnt;
  logic [chc_pkg::LEN_W-1:0]     acc_next;
  logic [chc_pkg::CSIZE_W-1:0]   rem_next;

  // Two restoring steps per cycle
  always_comb begin
    logic [chc_pkg::CSIZE_W:0] trial;
    acc_next = acc;
    rem_next = rem;
    for (int k = 0; k < chc_pkg::DIV_STEP_BITS; k++) begin
      trial = {rem_next, acc_next[chc_pkg::LEN_W-1]};
      if (trial >= {1'b0, dsr}) begin
        rem_next = chc_pkg::CSIZE_W'(trial - {1'b0, dsr});
        acc_next = {acc_next[chc_pkg::LEN_W-2:0], 1'b1};
      end else begin
        rem_next = trial[chc_pkg::CSIZE_W-1:0];
        acc_next = {acc_next[chc_pkg::LEN_W-2:0], 1'b0};
      end
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= chc_pkg::DIV_CNT_W'(chc_pkg::DIV_CYCLES);
    end else if (busy) begin
      cnt <= cnt - chc_pkg::DIV_CNT_W'(1);
      if (cnt == chc_pkg::DIV_CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      acc <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      acc <= acc_next;
      rem <= rem_next;
    end
  end

  // Round up when a remainder is left
  assign quotient = acc[chc_pkg::COUNT_W-1:0]
                  + {{(chc_pkg::COUNT_W-1){1'b0}}, |rem};

endmodule

`default_nettype wire

[hdl/chunk_header_compressor_core.sv]
// ----------------------------------------------------------------------------
// chunk_header_compressor_core: chunk header compression for outgoing messages
// Looks up the chunk stream in a small table held in RAM, picks the chunk
// header format from the previous header, writes the new header back and
// reports header sizes and chunk count.
//
//   Channel   Handshake                  Payload        Moves
//   req       req_valid / req_ready      chc_pkg::req_t  one message header
//   rsp       rsp_valid / rsp_ready      chc_pkg::rsp_t  one header decision
//   cfg       cfg_wr_en                  cfg_wr_data     chunk_size write
//
// Requests: one at a time; req_ready is high only in idle. A request is done
//   once the chunk count divider has finished and the table probe, one slot
//   a cycle, has found the stream or read every slot.
// Reset: table slots read as their preset contents until first written (one
//   valid flop per slot), so no clearing pass; chunk_size returns to 128.
// Stalls: a finished response waits in the output register while the next
//   request is taken and worked on; a request finishes only once that
//   register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module chunk_header_compressor_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           req_valid,
  output logic                                req_ready,
  input  wire chc_pkg::req_t                  req,
  output logic                                rsp_valid,
  input  wire logic                           rsp_ready,
  output chc_pkg::rsp_t                       rsp,
  input  wire logic                           cfg_wr_en,
  input  wire logic [chc_pkg::CSIZE_W-1:0]    cfg_wr_data
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PROBE  = 3'd1;
  localparam logic [2:0] ST_EVAL   = 3'd2;
  localparam logic [2:0] ST_DECIDE = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0]                      state;
  chc_pkg::req_t                   req_q;
  logic [chc_pkg::CSIZE_W-1:0]     chunk_size;
  logic [chc_pkg::CSIZE_W-1:0]     divisor;

  // Probe
  logic [chc_pkg::PROBE_W-1:0]     iss_cnt;
  logic                            issue;
  logic [chc_pkg::SLOT_W-1:0]      probe_addr;
  logic                            rd_vld;
  logic                            rd_last;
  logic [chc_pkg::SLOT_W-1:0]      rd_addr_q;
  logic [chc_pkg::ENTRY_W-1:0]     ram_rd_data;
  chc_pkg::slot_entry_t            ent;
  logic                            match;
  logic                            probe_fail;
  logic [chc_pkg::TABLE_SLOTS-1:0] slot_valid;

  // Matched entry and compare results
  chc_pkg::slot_entry_t            hit;
  logic [chc_pkg::SLOT_W-1:0]      hit_slot;
  logic                            found;
  logic                            ts_ge;
  logic [chc_pkg::STAMP_W-1:0]     delta;
  logic                            stream_eq;
  logic                            type_eq;
  logic                            len_eq;

  // Decision and write-back
  logic [chc_pkg::FMT_W-1:0]       fmt_next;
  logic [chc_pkg::STAMP_W-1:0]     stamp_next;
  logic [chc_pkg::FMT_W-1:0]       fmt_q;
  logic [chc_pkg::STAMP_W-1:0]     stamp_q;
  logic                            ram_wr_en;
  chc_pkg::slot_entry_t            entry_wr;

  // Divider and response
  logic                            div_start;
  logic                            div_busy;
  logic [chc_pkg::COUNT_W-1:0]     div_quot;
  logic                            rsp_load;
  chc_pkg::rsp_t                   rsp_next;
  logic                            id_ok;
  logic                            accept;

  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;
  assign id_ok     = (req.channel_id >= chc_pkg::ID_MIN)
                  && (req.channel_id <= chc_pkg::ID_MAX);

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_size <= chc_pkg::CHUNK_RESET;
    end else if (cfg_wr_en) begin
      chunk_size <= cfg_wr_data;
    end
  end

  assign divisor = (chunk_size < chc_pkg::CHUNK_MIN) ? chc_pkg::CHUNK_MIN : chunk_size;

  // Chunk count runs alongside the table work
  assign div_start = accept;

  chc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (req.msg_length),
    .divisor  (divisor),
    .busy     (div_busy),
    .quotient (div_quot)
  );

  // Probe addressing: start at id mod TABLE_SLOTS and wrap
  assign issue      = (state == ST_PROBE)
                   && (iss_cnt < chc_pkg::PROBE_W'(chc_pkg::TABLE_SLOTS));
  assign probe_addr = req_q.channel_id[chc_pkg::SLOT_W-1:0]
                    + iss_cnt[chc_pkg::SLOT_W-1:0];

  chc_ram #(
    .WIDTH (chc_pkg::ENTRY_W),
    .DEPTH (chc_pkg::TABLE_SLOTS)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (hit_slot),
    .wr_data (entry_wr),
    .rd_en   (issue),
    .rd_addr (probe_addr),
    .rd_data (ram_rd_data)
  );

  // Unwritten slots read as their preset contents
  assign ent        = slot_valid[rd_addr_q] ? chc_pkg::slot_entry_t'(ram_rd_data)
                                            : chc_pkg::preset_entry(rd_addr_q);
  assign match      = rd_vld && (ent.channel == req_q.channel_id);
  assign probe_fail = rd_vld && !match && rd_last;

  // Format choice from the registered compares
  always_comb begin
    fmt_next   = chc_pkg::FMT_FULL;
    stamp_next = req_q.msg_timestamp;
    if (req_q.allow_compress && ts_ge && (delta < chc_pkg::STAMP_LIMIT) && stream_eq) begin
      fmt_next   = chc_pkg::FMT_SAME_STRM;
      stamp_next = delta;
      if (type_eq && len_eq) begin
        fmt_next = chc_pkg::FMT_SAME_SHAPE;
        if (delta == hit.stamp) begin
          fmt_next = chc_pkg::FMT_SAME_DELTA;
        end
      end
    end
  end

  // Write-back of the new header; the next probe starts only after it lands
  assign ram_wr_en = (state == ST_DECIDE);
  always_comb begin
    entry_wr          = hit;
    entry_wr.format   = fmt_next;
    entry_wr.stamp    = stamp_next;
    entry_wr.length   = req_q.msg_length;
    entry_wr.msg_type = req_q.msg_type;
    entry_wr.stream   = req_q.msg_stream;
    entry_wr.clock    = req_q.msg_timestamp;
  end

  // Response assembly
  always_comb begin
    logic                       ext;
    logic [chc_pkg::FIRST_W-1:0] ext_bytes;
    ext       = (stamp_q >= chc_pkg::STAMP_LIMIT);
    ext_bytes = ext ? chc_pkg::FIRST_W'(chc_pkg::EXT_BYTES) : '0;
    rsp_next  = '0;
    if (!found) begin
      rsp_next.status = chc_pkg::STATUS_NO_CHANNEL;
    end else if (req_q.msg_length >= chc_pkg::LEN_LIMIT) begin
      rsp_next.status = chc_pkg::STATUS_TOO_LONG;
    end else begin
      rsp_next.status             = chc_pkg::STATUS_OK;
      rsp_next.header_format      = fmt_q;
      rsp_next.stamp_field        = stamp_q;
      rsp_next.extended_stamp     = ext;
      rsp_next.first_header_bytes =
          chc_pkg::FIRST_W'(chc_pkg::basic_bytes(req_q.channel_id))
        + chc_pkg::FIRST_W'(chc_pkg::msg_bytes(fmt_q)) + ext_bytes;
      rsp_next.next_header_bytes  =
          chc_pkg::NEXT_W'(chc_pkg::basic_bytes(req_q.channel_id))
        + ext_bytes[chc_pkg::NEXT_W-1:0];
      rsp_next.chunk_count        = div_quot;
    end
  end

  assign rsp_load = (state == ST_FINISH) && !div_busy && (!rsp_valid || rsp_ready);

  // Sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      iss_cnt    <= '0;
      rd_vld     <= 1'b0;
      rd_last    <= 1'b0;
      found      <= 1'b0;
      slot_valid <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      rd_vld  <= issue && !match;
      rd_last <= iss_cnt == chc_pkg::PROBE_W'(chc_pkg::TABLE_SLOTS - 1);
      if (issue) begin
        iss_cnt <= iss_cnt + chc_pkg::PROBE_W'(1);
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            iss_cnt <= '0;
            found   <= 1'b0;
            state   <= id_ok ? ST_PROBE : ST_FINISH;
          end
        end
        ST_PROBE: begin
          if (match) begin
            state <= ST_EVAL;
          end else if (probe_fail) begin
            state <= ST_FINISH;
          end
        end
        ST_EVAL: begin
          state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          found                <= 1'b1;
          slot_valid[hit_slot] <= 1'b1;
          state                <= ST_FINISH;
        end
        ST_FINISH: begin
          if (rsp_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
    end
    if (issue) begin
      rd_addr_q <= probe_addr;
    end
    if (state == ST_PROBE && match) begin
      hit      <= ent;
      hit_slot <= rd_addr_q;
    end
    if (state == ST_EVAL) begin
      ts_ge     <= req_q.msg_timestamp >= hit.clock;
      delta     <= req_q.msg_timestamp - hit.clock;
      stream_eq <= req_q.msg_stream == hit.stream;
      type_eq   <= req_q.msg_type == hit.msg_type;
      len_eq    <= req_q.msg_length == hit.length;
    end
    if (state == ST_DECIDE) begin
      fmt_q   <= fmt_next;
      stamp_q <= stamp_next;
    end
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

  // Assertions
  a_wb_slot_matches: assert property (@(posedge clk) disable iff (rst)
    ram_wr_en |-> hit.channel == req_q.channel_id)
    else $error("write-back to a slot that does not hold the request's id");

  a_div_started: assert property (@(posedge clk) disable iff (rst)
    accept |=> div_busy)
    else $error("divider not running after request accept");

  a_err_fields_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != chc_pkg::STATUS_OK |->
      rsp.chunk_count == '0 && rsp.first_header_bytes == '0 && rsp.stamp_field == '0)
    else $error("error response carries nonzero fields");

  a_first_ge_next: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == chc_pkg::STATUS_OK |->
      rsp.first_header_bytes >= chc_pkg::FIRST_W'(rsp.next_header_bytes))
    else $error("first chunk header shorter than continuation header");

endmodule

`default_nettype wire
